// ===== hdl/aws_pkg.sv =====
// Package for the audio waveshaper: register indexes, curve codes, exponential tables.
package aws_pkg;

    // Register indexes on the configuration channel
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_GAIN = 2'd1;
    localparam logic [1:0] REG_MIX  = 2'd2;

    // Curve selection codes
    typedef enum logic [2:0] {
        MODE_HARD = 3'd0,
        MODE_QUAD = 3'd1,
        MODE_EXP  = 3'd2,
        MODE_FULL = 3'd3,
        MODE_HALF = 3'd4
    } mode_t;

    // Quadratic soft-clip segments
    typedef enum logic [1:0] {
        SEG_LIN,
        SEG_CURVE,
        SEG_FLAT
    } seg_t;

    // Q.23 constants
    localparam int          Q_ONE   = 8388608;
    localparam logic [25:0] SOFT_T1 = 26'd2796202;
    localparam logic [25:0] SOFT_T2 = 26'd5592405;
    // ceil(2^25 / 3): exact divide by three for 24-bit operands after >> 25
    localparam logic [23:0] DIV3_MAGIC = 24'hAAAAAB;

    // Exponential table: e^(-8k/N) in Q.23
    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int IDX_W  = $clog2(EXP_TABLE_ENTRIES);
    localparam int I_W    = 1 + $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int P_W    = 26 + I_W;
    localparam int STEP_W = 22;

    // Taylor terms of e^(-8/N) in Q.31, each floor(previous * 8 / (N * n))
    localparam logic [63:0] TAY_DEN = 64'(EXP_TABLE_ENTRIES);
    localparam logic [63:0] TAY_0   = 64'd1 << 31;
    localparam logic [63:0] TAY_1   = TAY_0  * 64'd8 / (TAY_DEN * 64'd1);
    localparam logic [63:0] TAY_2   = TAY_1  * 64'd8 / (TAY_DEN * 64'd2);
    localparam logic [63:0] TAY_3   = TAY_2  * 64'd8 / (TAY_DEN * 64'd3);
    localparam logic [63:0] TAY_4   = TAY_3  * 64'd8 / (TAY_DEN * 64'd4);
    localparam logic [63:0] TAY_5   = TAY_4  * 64'd8 / (TAY_DEN * 64'd5);
    localparam logic [63:0] TAY_6   = TAY_5  * 64'd8 / (TAY_DEN * 64'd6);
    localparam logic [63:0] TAY_7   = TAY_6  * 64'd8 / (TAY_DEN * 64'd7);
    localparam logic [63:0] TAY_8   = TAY_7  * 64'd8 / (TAY_DEN * 64'd8);
    localparam logic [63:0] TAY_9   = TAY_8  * 64'd8 / (TAY_DEN * 64'd9);
    localparam logic [63:0] TAY_10  = TAY_9  * 64'd8 / (TAY_DEN * 64'd10);
    localparam logic [63:0] TAY_11  = TAY_10 * 64'd8 / (TAY_DEN * 64'd11);
    localparam logic [63:0] TAY_12  = TAY_11 * 64'd8 / (TAY_DEN * 64'd12);
    localparam logic [63:0] TAY_13  = TAY_12 * 64'd8 / (TAY_DEN * 64'd13);
    localparam logic [63:0] TAY_14  = TAY_13 * 64'd8 / (TAY_DEN * 64'd14);
    localparam logic [63:0] TAY_15  = TAY_14 * 64'd8 / (TAY_DEN * 64'd15);
    localparam logic [63:0] TAY_16  = TAY_15 * 64'd8 / (TAY_DEN * 64'd16);
    localparam logic [63:0] TAY_17  = TAY_16 * 64'd8 / (TAY_DEN * 64'd17);
    localparam logic [63:0] TAY_18  = TAY_17 * 64'd8 / (TAY_DEN * 64'd18);
    localparam logic [63:0] TAY_19  = TAY_18 * 64'd8 / (TAY_DEN * 64'd19);
    localparam logic [63:0] TAY_20  = TAY_19 * 64'd8 / (TAY_DEN * 64'd20);
    localparam logic [63:0] TAY_POS = TAY_0 + TAY_2 + TAY_4 + TAY_6 + TAY_8 + TAY_10
                                      + TAY_12 + TAY_14 + TAY_16 + TAY_18 + TAY_20;
    localparam logic [63:0] TAY_NEG = TAY_1 + TAY_3 + TAY_5 + TAY_7 + TAY_9 + TAY_11
                                      + TAY_13 + TAY_15 + TAY_17 + TAY_19;
    localparam logic [63:0] EXP_RATIO = TAY_POS - TAY_NEG;

    typedef logic [63:0]       exp_rom_t  [EXP_TABLE_ENTRIES + 1];
    typedef logic [23:0]       exp_base_t [EXP_TABLE_ENTRIES];
    typedef logic [STEP_W-1:0] exp_step_t [EXP_TABLE_ENTRIES];

    function automatic exp_rom_t build_exp_rom();
        logic [63:0] v;
        exp_rom_t    rom;
        v = 64'd1 << 31;
        rom[0] = 64'd1 << 23;
        for (int k = 1; k <= EXP_TABLE_ENTRIES; k++) begin
            v = (v * EXP_RATIO + (64'd1 << 30)) >> 31;
            rom[k] = (v + 64'd128) >> 8;
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

    function automatic exp_base_t build_exp_base();
        exp_base_t t;
        for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
            t[k] = EXP_ROM[k][23:0];
        end
        return t;
    endfunction

    function automatic exp_step_t build_exp_step();
        exp_step_t  t;
        logic [63:0] dif;
        for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
            dif  = EXP_ROM[k] - EXP_ROM[k + 1];
            t[k] = dif[STEP_W-1:0];
        end
        return t;
    endfunction

    localparam exp_base_t   EXP_BASE = build_exp_base();
    localparam exp_step_t   EXP_STEP = build_exp_step();
    localparam logic [23:0] EXP_END  = EXP_ROM[EXP_TABLE_ENTRIES][23:0];

endpackage

// ===== hdl/audio_waveshaper_distortion.sv =====
// Audio waveshaper top level: gain, five distortion curves, wet/dry blend, saturation.
// Ten-stage pipeline, one Q1.23 word in and one out per cycle while m_tready does not hold
// the output. Depth is set by the chain gain multiply -> rounding -> table lookup ->
// square/interpolate -> divide by three -> blend products -> round and clamp, with at most
// one multiply deep per stage. Each stage loads whenever it is empty or the stage after it
// moves, so bubbles close up and a held output does not stop earlier stages filling.
// Curves: 0 hard clip at +-1, 1 three-segment quadratic soft clip, 2 exponential soft clip
// via an interpolated table, 3 full-wave rectify, 4 half-wave rectify; codes 5 to 7 pass
// the gained sample. mix_fraction above 256 counts as 256. A wet +1.0 cannot be represented
// and comes out as full scale with saturated set. Configuration is a plain write channel
// (always ready) and must only be used while idle.
module audio_waveshaper_distortion (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] sample_in
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [23:0] sample_out
    output logic [0:0]  m_tuser    // [0] saturated
);

    localparam int NSTG = 10;

    // ---------------- configuration registers ----------------
    logic [2:0]  mode_reg;
    logic [15:0] gain_reg;
    logic [8:0]  mix_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= '0;
            gain_reg <= '0;
            mix_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                aws_pkg::REG_MODE: mode_reg <= cfg_data[2:0];
                aws_pkg::REG_GAIN: gain_reg <= cfg_data;
                aws_pkg::REG_MIX:  mix_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage valids and load enables ----------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: input capture ----------------
    logic signed [23:0] x0_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x0_reg <= s_tdata;
        end
    end

    // ---------------- stage 1: gain multiply ----------------
    logic signed [40:0] prod1_next, prod1_reg;

    assign prod1_next = 41'(x0_reg) * 41'($signed({1'b0, gain_reg}));

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            prod1_reg <= prod1_next;
        end
    end

    // ---------------- stage 2: round to Q.23, magnitude ----------------
    logic signed [40:0] rnd2;
    logic signed [26:0] d2_next, d2_reg, abs2;
    logic [25:0]        a2_reg;

    always_comb begin
        rnd2    = prod1_reg + 41'sd4096;
        d2_next = rnd2[39:13];
        abs2    = d2_next[26] ? -d2_next : d2_next;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            d2_reg <= d2_next;
            a2_reg <= abs2[25:0];
        end
    end

    // ---------------- stage 3: segment, table lookup ----------------
    logic [27:0]                a3x;
    logic [23:0]                e3_next, e3_reg;
    aws_pkg::seg_t              seg3_next, seg3_reg;
    logic [26:0]                ac3;
    logic [aws_pkg::P_W-1:0]    p3;
    logic [aws_pkg::I_W-1:0]    i3;
    logic [23:0]                base3_next, base3_reg;
    logic [aws_pkg::STEP_W-1:0] step3_next, step3_reg;
    logic [25:0]                f3_reg;
    logic signed [26:0]         d3_reg;
    logic [25:0]                a3_reg;

    always_comb begin
        a3x     = {2'b00, a2_reg} + {1'b0, a2_reg, 1'b0};
        e3_next = 24'(28'h1000000 - a3x);
        if (a2_reg > aws_pkg::SOFT_T2) begin
            seg3_next = aws_pkg::SEG_FLAT;
        end else if (a2_reg > aws_pkg::SOFT_T1) begin
            seg3_next = aws_pkg::SEG_CURVE;
        end else begin
            seg3_next = aws_pkg::SEG_LIN;
        end
        // magnitude never reaches 2^26, so the clamp is only the zero-extension
        ac3 = {1'b0, a2_reg};
        p3  = aws_pkg::P_W'(ac3) * aws_pkg::P_W'(aws_pkg::EXP_TABLE_ENTRIES);
        i3  = p3[aws_pkg::P_W-1:26];
        if (i3 >= aws_pkg::I_W'(aws_pkg::EXP_TABLE_ENTRIES)) begin
            base3_next = aws_pkg::EXP_END;
            step3_next = '0;
        end else begin
            base3_next = aws_pkg::EXP_BASE[i3[aws_pkg::IDX_W-1:0]];
            step3_next = aws_pkg::EXP_STEP[i3[aws_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            e3_reg    <= e3_next;
            seg3_reg  <= seg3_next;
            base3_reg <= base3_next;
            step3_reg <= step3_next;
            f3_reg    <= p3[25:0];
            d3_reg    <= d2_reg;
            a3_reg    <= a2_reg;
        end
    end

    // ---------------- stage 4: square and interpolation products ----------------
    logic [47:0]        sq4_reg, ip4_reg;
    logic [23:0]        base4_reg;
    aws_pkg::seg_t      seg4_reg;
    logic signed [26:0] d4_reg;
    logic [25:0]        a4_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            sq4_reg   <= 48'(e3_reg) * 48'(e3_reg);
            ip4_reg   <= 48'(step3_reg) * 48'(f3_reg);
            base4_reg <= base3_reg;
            seg4_reg  <= seg3_reg;
            d4_reg    <= d3_reg;
            a4_reg    <= a3_reg;
        end
    end

    // ---------------- stage 5: scale square, interpolate table ----------------
    logic [47:0]        sq5;
    logic [48:0]        ip5;
    logic [23:0]        u5_reg, ex5_reg;
    aws_pkg::seg_t      seg5_reg;
    logic signed [26:0] d5_reg;
    logic [25:0]        a5_reg;

    always_comb begin
        sq5 = sq4_reg + 48'd12582912;           // 3 * 2^22
        ip5 = {1'b0, ip4_reg} + 49'd33554432;   // 2^25
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            u5_reg   <= sq5[46:23];
            ex5_reg  <= base4_reg - {1'b0, ip5[48:26]};
            seg5_reg <= seg4_reg;
            d5_reg   <= d4_reg;
            a5_reg   <= a4_reg;
        end
    end

    // ---------------- stage 6: divide by three, exponential magnitude ----------------
    logic [47:0]        q6_prod;
    logic [22:0]        q6_reg;
    logic [23:0]        xm6_reg;
    aws_pkg::seg_t      seg6_reg;
    logic signed [26:0] d6_reg;
    logic [25:0]        a6_reg;

    assign q6_prod = 48'(u5_reg) * 48'(aws_pkg::DIV3_MAGIC);

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            q6_reg   <= q6_prod[47:25];
            xm6_reg  <= 24'(aws_pkg::Q_ONE) - ex5_reg;
            seg6_reg <= seg5_reg;
            d6_reg   <= d5_reg;
            a6_reg   <= a5_reg;
        end
    end

    // ---------------- stage 7: curve select ----------------
    logic [23:0]        qm7;
    logic signed [26:0] qs7, xs7, w7_next, w7_reg, d7_reg;
    logic               neg7;

    always_comb begin
        neg7 = d6_reg[26];
        case (seg6_reg)
            aws_pkg::SEG_FLAT:  qm7 = 24'(aws_pkg::Q_ONE);
            aws_pkg::SEG_CURVE: qm7 = 24'(aws_pkg::Q_ONE) - {1'b0, q6_reg};
            default:            qm7 = {a6_reg[22:0], 1'b0};
        endcase
        qs7 = neg7 ? -$signed({3'b000, qm7}) : $signed({3'b000, qm7});
        xs7 = neg7 ? -$signed({3'b000, xm6_reg}) : $signed({3'b000, xm6_reg});
        case (mode_reg)
            aws_pkg::MODE_HARD: begin
                if (d6_reg > 27'sd8388608) begin
                    w7_next = 27'sd8388608;
                end else if (d6_reg < -27'sd8388608) begin
                    w7_next = -27'sd8388608;
                end else begin
                    w7_next = d6_reg;
                end
            end
            aws_pkg::MODE_QUAD: w7_next = qs7;
            aws_pkg::MODE_EXP:  w7_next = xs7;
            aws_pkg::MODE_FULL: w7_next = $signed({1'b0, a6_reg});
            aws_pkg::MODE_HALF: w7_next = neg7 ? '0 : d6_reg;
            default:            w7_next = d6_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            w7_reg <= w7_next;
            d7_reg <= d6_reg;
        end
    end

    // ---------------- stage 8: blend products ----------------
    logic [8:0]         mw8, md8;
    logic signed [36:0] pw8_reg, pd8_reg;

    always_comb begin
        mw8 = (mix_reg > 9'd256) ? 9'd256 : mix_reg;
        md8 = 9'd256 - mw8;
    end

    always_ff @(posedge aclk) begin
        if (en[8]) begin
            pw8_reg <= 37'(w7_reg) * 37'($signed({1'b0, mw8}));
            pd8_reg <= 37'(d7_reg) * 37'($signed({1'b0, md8}));
        end
    end

    // ---------------- stage 9: round, clamp, output register ----------------
    logic signed [37:0] sum9;
    logic signed [29:0] y9;
    logic [23:0]        out9_next, out9_reg;
    logic               sat9_next, sat9_reg;

    always_comb begin
        sum9 = 38'(pw8_reg) + 38'(pd8_reg) + 38'sd128;
        y9   = sum9[37:8];
        if (y9 > 30'sd8388607) begin
            out9_next = 24'h7FFFFF;
            sat9_next = 1'b1;
        end else if (y9 < -30'sd8388608) begin
            out9_next = 24'h800000;
            sat9_next = 1'b1;
        end else begin
            out9_next = y9[23:0];
            sat9_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[9]) begin
            out9_reg <= out9_next;
            sat9_reg <= sat9_next;
        end
    end

    assign m_tvalid   = vld_reg[NSTG-1];
    assign m_tdata    = out9_reg;
    assign m_tuser[0] = sat9_reg;

    // ---------------- assertions ----------------
    a_sat_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == 24'h7FFFFF || m_tdata == 24'h800000))
        else $error("saturated word not at full scale");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&vld_reg) && !m_tready)
        else $error("input stalled with an empty stage");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule
